@@ rtl/las_pkg.sv @@
// shared types and constants for the local alignment score block
// used by las_cell, local_alignment_score, las_checker and testbench; depends on nothing else

package las_pkg;

   // score, symbol, penalty, length and register index widths
   localparam int SCORE_W   = 16;
   localparam int SYM_W     = 8;
   localparam int PEN_W     = 8;
   localparam int LEN_W     = 9;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_LENGTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_REWARD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH_PENALTY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_PENALTY      = 2'd3;

   // request kinds
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_SCORE = 1'b1;

   // scoring weights broadcast to every cell
   typedef struct packed {
      logic [PEN_W-1:0] match_reward;
      logic [PEN_W-1:0] mismatch_penalty;
      logic [PEN_W-1:0] gap_penalty;
   } score_cfg_type;

   // wavefront handed from one cell to the next
   typedef struct packed {
      logic               run;
      logic [SYM_W-1:0]   sym;
      logic [SCORE_W-1:0] up;
      logic [SCORE_W-1:0] diag;
      logic [SCORE_W-1:0] cbest;
   } link_type;

endpackage

@@ rtl/las_cell.sv @@
// one query row of the scoring chain: query symbol, column score, cell update
// depends on las_pkg

module las_cell #(
   parameter int ROW   = 0,
   parameter int IDX_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  logic                            wr_en,
   input  logic [las_pkg::SYM_W-1:0]       wr_pos,
   input  logic [las_pkg::SYM_W-1:0]       wr_sym,
   input  logic [IDX_W-1:0]                last_row,
   input  las_pkg::score_cfg_type          cfg,
   input  las_pkg::link_type               link_in,
   output las_pkg::link_type               link_out,
   output logic                            done
);

   logic [las_pkg::SYM_W-1:0]   qsym_ff;
   logic [las_pkg::SCORE_W-1:0] score_ff;
   logic [las_pkg::SCORE_W-1:0] score_in;
   logic                        run_ff;
   logic                        done_ff;
   logic [las_pkg::SYM_W-1:0]   sym_ff;
   logic [las_pkg::SCORE_W-1:0] up_ff;
   logic [las_pkg::SCORE_W-1:0] diag_ff;
   logic [las_pkg::SCORE_W-1:0] cbest_ff;
   logic                        is_last;
   logic signed [17:0]          diag_s;
   logic signed [17:0]          up_s;
   logic signed [17:0]          left_s;
   logic signed [17:0]          h_s;
   logic [las_pkg::SCORE_W-1:0] h;
   logic [las_pkg::SCORE_W-1:0] cbest_in;

   assign is_last = (last_row == IDX_W'(ROW));

   // candidate scores in a signed range wide enough for saturation
   always_comb begin
      if (qsym_ff == link_in.sym) begin
         diag_s = $signed({2'b00, link_in.diag}) + $signed({10'd0, cfg.match_reward});
      end else begin
         diag_s = $signed({2'b00, link_in.diag}) - $signed({10'd0, cfg.mismatch_penalty});
      end
      up_s   = $signed({2'b00, link_in.up}) - $signed({10'd0, cfg.gap_penalty});
      left_s = $signed({2'b00, score_ff}) - $signed({10'd0, cfg.gap_penalty});
   end

   // max of zero and the three moves, then clamp to the score range
   always_comb begin
      h_s = 18'sd0;
      if (diag_s > h_s) begin
         h_s = diag_s;
      end
      if (up_s > h_s) begin
         h_s = up_s;
      end
      if (left_s > h_s) begin
         h_s = left_s;
      end
      if (h_s > 18'sd65535) begin
         h = '1;
      end else begin
         h = h_s[las_pkg::SCORE_W-1:0];
      end
      cbest_in = (h > link_in.cbest) ? h : link_in.cbest;
   end

   // column score of this row
   always_comb begin
      score_in = score_ff;
      if (clear) begin
         score_in = '0;
      end else if (link_in.run) begin
         score_in = h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
      end else begin
         score_ff <= score_in;
      end
   end

   // query symbol, no reset
   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_pos) == ROW)) begin
         qsym_ff <= wr_sym;
      end
   end

   // wavefront control to the next row
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= link_in.run && !is_last;
         done_ff <= link_in.run && is_last;
      end
   end

   // wavefront payload to the next row
   always_ff @(posedge clock) begin
      if (link_in.run) begin
         sym_ff   <= link_in.sym;
         up_ff    <= h;
         diag_ff  <= score_ff;
         cbest_ff <= cbest_in;
      end
   end

   assign link_out.run   = run_ff;
   assign link_out.sym   = sym_ff;
   assign link_out.up    = up_ff;
   assign link_out.diag  = diag_ff;
   assign link_out.cbest = cbest_ff;
   assign done           = done_ff;

endmodule

@@ rtl/local_alignment_score.sv @@
// Local alignment scoring (Smith-Waterman, linear gap) over a chain of
// QUERY_MAX row cells. A load request (tuser cmd 0) writes one query symbol
// into the cell at its position; positions at or past QUERY_MAX are dropped.
// A score request (cmd 1) sends a wavefront down the chain, one row per
// cycle, through min(query_length, QUERY_MAX) rows; no new request is taken
// until it leaves the last row, or for a query_length of zero until its
// response is made. The first flag clears all column scores and the best
// score in the cycle the request is accepted. Each score request gives one
// response: best score in tdata[15:0], column best in tdata[31:16], and the
// request's tlast echoed. A two-entry output buffer lets one more request
// run while a response waits; with both entries full, requests stall until
// the response side takes one. No clearing pass is needed after reset. The
// user must see that configuration is written only while the block is idle;
// the block itself does not enforce it.
// depends on las_pkg and las_cell

module local_alignment_score #(
   parameter int QUERY_MAX = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // symbol[7:0], position[15:8]
   input  logic [1:0]                        req_tuser,  // cmd[0], first[1]
   input  logic                              req_tlast,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // best_score[15:0], column_best[31:16]
   output logic                              rsp_tlast,
   // configuration
   input  logic                              csr_we,
   input  logic [las_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [las_pkg::LEN_W-1:0]         csr_wdata
);

   localparam int IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
   localparam int ROW_W = $clog2(QUERY_MAX + 1);

   // configuration registers
   logic [las_pkg::LEN_W-1:0]   qlen_ff;
   las_pkg::score_cfg_type      cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff                  <= las_pkg::LEN_W'(1);
         cfg_ff.match_reward      <= 8'd1;
         cfg_ff.mismatch_penalty  <= 8'd1;
         cfg_ff.gap_penalty       <= 8'd2;
      end else if (csr_we) begin
         case (csr_index)
            las_pkg::CSR_QUERY_LENGTH:     qlen_ff <= csr_wdata;
            las_pkg::CSR_MATCH_REWARD:     cfg_ff.match_reward <= csr_wdata[7:0];
            las_pkg::CSR_MISMATCH_PENALTY: cfg_ff.mismatch_penalty <= csr_wdata[7:0];
            las_pkg::CSR_GAP_PENALTY:      cfg_ff.gap_penalty <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // request decode
   logic                        req_acc;
   logic                        score_acc;
   logic                        load_acc;
   logic                        clear_acc;
   logic [las_pkg::SYM_W-1:0]   req_sym;
   logic [las_pkg::SYM_W-1:0]   req_pos;
   logic [ROW_W-1:0]            rows;

   assign req_sym   = req_tdata[7:0];
   assign req_pos   = req_tdata[15:8];
   assign req_acc   = req_tvalid && req_tready;
   assign score_acc = req_acc && (req_tuser[0] == las_pkg::CMD_SCORE);
   assign load_acc  = req_acc && (req_tuser[0] == las_pkg::CMD_LOAD);
   assign clear_acc = score_acc && req_tuser[1];

   // rows used, clamped to the chain length
   always_comb begin
      if (32'(qlen_ff) > QUERY_MAX) begin
         rows = ROW_W'(QUERY_MAX);
      end else begin
         rows = ROW_W'(qlen_ff);
      end
   end

   // control state of the request in flight
   logic                        busy_ff;
   logic                        busy_in;
   logic                        zero_ff;
   logic                        last_ff;
   logic [IDX_W-1:0]            last_row_ff;
   las_pkg::link_type           start_ff;
   logic                        chain_done;
   logic                        ev;
   logic [las_pkg::SCORE_W-1:0] ev_cbest;

   assign ev = chain_done || zero_ff;

   always_comb begin
      busy_in = busy_ff;
      if (score_acc) begin
         busy_in = 1'b1;
      end else if (ev) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         zero_ff <= score_acc && (rows == '0);
      end
   end

   // wavefront seed and request payload
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff.run <= 1'b0;
      end else begin
         start_ff.run <= score_acc && (rows != '0);
      end
      if (score_acc) begin
         start_ff.sym   <= req_sym;
         start_ff.up    <= '0;
         start_ff.diag  <= '0;
         start_ff.cbest <= '0;
         last_ff        <= req_tlast;
         last_row_ff    <= IDX_W'(rows - ROW_W'(1));
      end
   end

   // chain of row cells
   las_pkg::link_type           links [0:QUERY_MAX];
   logic [QUERY_MAX-1:0]        done_vec;

   assign links[0] = start_ff;

   for (genvar g = 0; g < QUERY_MAX; g++) begin : g_row
      las_cell #(
         .ROW   (g),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear_acc),
         .wr_en    (load_acc),
         .wr_pos   (req_pos),
         .wr_sym   (req_sym),
         .last_row (last_row_ff),
         .cfg      (cfg_ff),
         .link_in  (links[g]),
         .link_out (links[g+1]),
         .done     (done_vec[g])
      );
   end

   // pick the column best from the row that finished
   always_comb begin
      ev_cbest = '0;
      for (int i = 0; i < QUERY_MAX; i++) begin
         ev_cbest = ev_cbest | (done_vec[i] ? links[i+1].cbest : '0);
      end
   end

   assign chain_done = |done_vec;

   // running best of the sequence
   logic [las_pkg::SCORE_W-1:0] best_ff;
   logic [las_pkg::SCORE_W-1:0] best_in;
   logic [las_pkg::SCORE_W-1:0] new_best;

   assign new_best = (ev_cbest > best_ff) ? ev_cbest : best_ff;

   always_comb begin
      best_in = best_ff;
      if (clear_acc) begin
         best_in = '0;
      end else if (ev) begin
         best_in = new_best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   // output register plus skid entry
   logic        out_valid_ff;
   logic [31:0] out_data_ff;
   logic        out_last_ff;
   logic        skid_valid_ff;
   logic [31:0] skid_data_ff;
   logic        skid_last_ff;
   logic        take;
   logic        out_free;
   logic [31:0] ev_data;

   assign take     = out_valid_ff && rsp_tready;
   assign out_free = !out_valid_ff || take;
   assign ev_data  = {ev_cbest, new_best};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff && take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else if (ev) begin
            if (out_free) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && take) begin
         out_data_ff <= skid_data_ff;
         out_last_ff <= skid_last_ff;
      end else if (ev && out_free) begin
         out_data_ff <= ev_data;
         out_last_ff <= last_ff;
      end
      if (ev && !out_free) begin
         skid_data_ff <= ev_data;
         skid_last_ff <= last_ff;
      end
   end

   assign req_tready = !busy_ff && !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ dv/las_checker.sv @@
`timescale 1ns / 1ps
// checker for local_alignment_score: watches the request, response and csr ports,
// predicts each response from its own copy of the scoring state and compares
// depends on las_pkg

module las_checker #(
   parameter int QUERY_MAX = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [15:0]                   req_tdata,  // symbol[7:0], position[15:8]
   input  logic [1:0]                    req_tuser,  // cmd[0], first[1]
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [31:0]                   rsp_tdata,  // best_score[15:0], column_best[31:16]
   input  logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [las_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [las_pkg::LEN_W-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            pending_count
);

   localparam int SCORE_CAP = 65535;

   typedef struct packed {
      logic [las_pkg::SCORE_W-1:0] best;
      logic [las_pkg::SCORE_W-1:0] column;
      logic                        eos;
   } score_result_type;

   // predicted responses, oldest first
   score_result_type score_q[$];

   // scoring state and weights
   logic [las_pkg::SYM_W-1:0]   query_sym    [QUERY_MAX];
   logic [las_pkg::SCORE_W-1:0] column_score [QUERY_MAX];
   logic [las_pkg::SCORE_W-1:0] best_so_far;
   logic [las_pkg::LEN_W-1:0]   query_len;
   logic [las_pkg::PEN_W-1:0]   reward;
   logic [las_pkg::PEN_W-1:0]   mismatch;
   logic [las_pkg::PEN_W-1:0]   gap;

   // one database symbol: compute the new column and queue the response
   task automatic score_column(input logic [las_pkg::SYM_W-1:0] sym, input logic first,
                               input logic last);
      int rows;
      int diag_prev;
      int up;
      int left;
      int diag;
      int h;
      int gp;
      int col_best;
      score_result_type r;
      if (first) begin
         foreach (column_score[i]) column_score[i] = '0;
         best_so_far = '0;
      end
      rows = (int'(query_len) > QUERY_MAX) ? QUERY_MAX : int'(query_len);
      diag_prev = 0;
      up = 0;
      col_best = 0;
      gp = int'(gap);
      for (int i = 0; i < rows; i++) begin
         left = int'(column_score[i]);
         if (query_sym[i] == sym) diag = diag_prev + int'(reward);
         else diag = diag_prev - int'(mismatch);
         h = 0;
         if (diag > h) h = diag;
         if (up - gp > h) h = up - gp;
         if (left - gp > h) h = left - gp;
         if (h > SCORE_CAP) h = SCORE_CAP;
         column_score[i] = h[las_pkg::SCORE_W-1:0];
         diag_prev = left;
         up = h;
         if (h > col_best) col_best = h;
      end
      if (col_best > int'(best_so_far)) best_so_far = col_best[las_pkg::SCORE_W-1:0];
      r.best = best_so_far;
      r.column = col_best[las_pkg::SCORE_W-1:0];
      r.eos = last;
      score_q = {score_q, r};
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      score_result_type want;
      if (reset) begin
         foreach (column_score[i]) column_score[i] = '0;
         best_so_far = '0;
         query_len = 9'd1;
         reward = 8'd1;
         mismatch = 8'd1;
         gap = 8'd2;
         score_q.delete();
         mismatch_count = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               las_pkg::CSR_QUERY_LENGTH:     query_len = csr_wdata[las_pkg::LEN_W-1:0];
               las_pkg::CSR_MATCH_REWARD:     reward = csr_wdata[las_pkg::PEN_W-1:0];
               las_pkg::CSR_MISMATCH_PENALTY: mismatch = csr_wdata[las_pkg::PEN_W-1:0];
               las_pkg::CSR_GAP_PENALTY:      gap = csr_wdata[las_pkg::PEN_W-1:0];
               default: ;
            endcase
         end
         // responses against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (score_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response: expected none actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = score_q.pop_front();
               check_field("best_score", int'(want.best), int'(rsp_tdata[15:0]));
               check_field("column_best", int'(want.column), int'(rsp_tdata[31:16]));
               check_field("end_of_sequence", int'(want.eos), int'(rsp_tlast));
            end
         end
         // accepted requests
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == las_pkg::CMD_LOAD) begin
               if (int'(req_tdata[15:8]) < QUERY_MAX) query_sym[req_tdata[15:8]] = req_tdata[7:0];
            end else begin
               score_column(req_tdata[7:0], req_tuser[1], req_tlast);
            end
         end
      end
      pending_count <= score_q.size();
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// top of the local_alignment_score testbench: clock, reset, request and csr stimulus,
// response back-pressure and verdict; uses las_pkg, las_checker, local_alignment_score

module testbench;

   localparam int QUERY_MAX = 256;
   localparam int DRAIN_CYCLES = QUERY_MAX + 8;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [15:0]                   req_tdata = '0;   // symbol[7:0], position[15:8]
   logic [1:0]                    req_tuser = '0;   // cmd[0], first[1]
   logic                          req_tlast = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [31:0]                   rsp_tdata;        // best_score[15:0], column_best[31:16]
   logic                          rsp_tlast;
   logic                          csr_we = 1'b0;
   logic [las_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [las_pkg::LEN_W-1:0]     csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int send_gap_pct = 29;
   int recv_stall_pct = 85;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   local_alignment_score #(.QUERY_MAX(QUERY_MAX)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   las_checker #(.QUERY_MAX(QUERY_MAX)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // response back-pressure, with a long hold-off each time the token moves
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // mostly a small alphabet so that matches are common
   function automatic logic [las_pkg::SYM_W-1:0] pick_symbol();
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(3));
   endfunction

   // offer one request and hold it until accepted
   task automatic push_req(input logic cmd, input logic [7:0] sym, input logic [7:0] pos,
                           input logic first, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pos, sym};
      req_tuser <= {first, cmd};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load(input logic [7:0] pos, input logic [7:0] sym);
      push_req(las_pkg::CMD_LOAD, sym, pos, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic score(input logic [7:0] sym, input logic first, input logic last);
      push_req(las_pkg::CMD_SCORE, sym, 8'($urandom_range(255)), first, last);
   endtask

   // stop sending, wait for every response, then let the chain empty
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_weights(input logic [las_pkg::LEN_W-1:0] qlen,
                              input logic [las_pkg::PEN_W-1:0] mr,
                              input logic [las_pkg::PEN_W-1:0] mm,
                              input logic [las_pkg::PEN_W-1:0] gp);
      csr_we <= 1'b1;
      csr_index <= las_pkg::CSR_QUERY_LENGTH;
      csr_wdata <= qlen;
      @(posedge clock);
      csr_index <= las_pkg::CSR_MATCH_REWARD;
      csr_wdata <= las_pkg::LEN_W'(mr);
      @(posedge clock);
      csr_index <= las_pkg::CSR_MISMATCH_PENALTY;
      csr_wdata <= las_pkg::LEN_W'(mm);
      @(posedge clock);
      csr_index <= las_pkg::CSR_GAP_PENALTY;
      csr_wdata <= las_pkg::LEN_W'(gp);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random mix: mostly whole database sequences, some loads and stray flags
   task automatic run_phase(input int target);
      int done;
      int n;
      int r;
      done = 0;
      while (done < target) begin
         r = $urandom_range(99);
         if (r < 8) begin
            load(8'($urandom_range(255)), pick_symbol());
            done++;
         end else if (r < 16) begin
            score(pick_symbol(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            done++;
         end else begin
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++) score(pick_symbol(), k == 0, k == n - 1);
            done += n;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_weights(9'd1, 8'd1, 8'd1, 8'd2);

      // fill every query row so no unwritten entry is ever read
      for (int p = 0; p < QUERY_MAX; p++)
         load(8'(p), (p == 0) ? 8'h00 : (p == QUERY_MAX - 1) ? 8'hFF : pick_symbol());

      // directed: default weights, symbol extremes, first and last
      score(8'h00, 1'b1, 1'b0);
      score(8'hFF, 1'b0, 1'b1);
      score(8'h00, 1'b1, 1'b1);
      // zero rows: no cells, best unchanged
      settle();
      set_weights(9'd0, 8'd1, 8'd1, 8'd2);
      score(8'h00, 1'b1, 1'b1);
      score(8'h03, 1'b0, 1'b0);
      // length past the chain is clamped, heavy reward
      settle();
      set_weights(9'd511, 8'd255, 8'd0, 8'd0);
      score(8'h00, 1'b1, 1'b0);
      score(8'h01, 1'b0, 1'b0);
      score(8'hFF, 1'b0, 1'b1);
      // length change in the middle of a sequence
      settle();
      set_weights(9'd8, 8'd3, 8'd1, 8'd1);
      score(8'h00, 1'b1, 1'b0);
      score(8'h01, 1'b0, 1'b0);
      settle();
      set_weights(9'd4, 8'd3, 8'd1, 8'd1);
      score(8'h02, 1'b0, 1'b0);
      settle();
      set_weights(9'd8, 8'd3, 8'd1, 8'd1);
      score(8'h03, 1'b0, 1'b1);
      // loads at the position extremes, flags ignored
      load(8'hFF, 8'hFF);
      load(8'h00, 8'h00);

      // random phases over several weight settings and idle patterns
      for (int p = 0; p < 12; p++) begin
         settle();
         if (p == 4) begin
            send_gap_pct = 85;
            recv_stall_pct = 29;
         end else if (p == 8) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         case (p)
            2: set_weights(9'd256, 8'd255, 8'd255, 8'd255);
            6: set_weights(9'd256, 8'd255, 8'd0, 8'd0);
            9: set_weights(9'd1, 8'd0, 8'd0, 8'd0);
            default: set_weights(($urandom_range(7) == 0) ? 9'($urandom_range(25, 64))
                                                          : 9'($urandom_range(1, 24)),
                                 8'($urandom_range(0, 6)), 8'($urandom_range(0, 5)),
                                 8'($urandom_range(0, 5)));
         endcase
         // long response hold-off while requests keep coming
         if (p == 1 || p == 10) begin
            hold_token <= hold_token + 1;
            for (int k = 0; k < 24; k++) score(pick_symbol(), k == 0, k == 23);
         end
         run_phase((p == 2 || p == 6) ? 20 : 22);
      end

      settle();
      if (mismatch_count == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule
